@@ hdl/qdpe_pkg.sv @@
//------------------------------------------------------------------------------
// qdpe_pkg
// Shared types, constants and the divider step for the delta pixel encoder.
//------------------------------------------------------------------------------
`default_nettype none

package qdpe_pkg;

   localparam int unsigned PixW     = 8;
   localparam int unsigned NumChan  = 3;
   localparam int unsigned ChanW    = 2;
   localparam int unsigned AddrW    = 3;
   localparam int unsigned DataW    = 32;

   localparam logic [PixW-1:0] CodeBias  = 8'd127;
   localparam logic [PixW-1:0] StepReset = 8'd1;

   // register map
   localparam logic [0:0] RegQuantStep = 1'b0;

   localparam logic [ChanW-1:0] ChanRed   = 2'd0;
   localparam logic [ChanW-1:0] ChanGreen = 2'd1;
   localparam logic [ChanW-1:0] ChanBlue  = 2'd2;

   typedef struct packed {
      logic [PixW-1:0] pixel_red;
      logic [PixW-1:0] pixel_green;
      logic [PixW-1:0] pixel_blue;
      logic            row_start;
   } req_data_type;

   typedef struct packed {
      logic [PixW-1:0] code_red;
      logic [PixW-1:0] code_green;
      logic [PixW-1:0] code_blue;
      logic [PixW-1:0] recon_red;
      logic [PixW-1:0] recon_green;
      logic [PixW-1:0] recon_blue;
   } rsp_data_type;

   typedef enum logic [4:0] {
      StIdle   = 5'b00001,
      StSetup  = 5'b00010,
      StDiv    = 5'b00100,
      StPost   = 5'b01000,
      StFinish = 5'b10000
   } state_type;

   // one restoring division step: returns {quotient bit, new remainder}
   function automatic logic [PixW:0] div_step(input logic [PixW-1:0] rem,
                                              input logic            nbit,
                                              input logic [PixW-1:0] step);
      logic [PixW:0] shifted;
      logic [PixW:0] diff;
      shifted = {rem, nbit};
      diff    = shifted - {1'b0, step};
      if (shifted >= {1'b0, step}) begin
         div_step = {1'b1, diff[PixW-1:0]};
      end else begin
         div_step = {1'b0, shifted[PixW-1:0]};
      end
   endfunction

endpackage

`default_nettype wire

@@ hdl/quantized_delta_pixel_encoder_core.sv @@
//------------------------------------------------------------------------------
// quantized_delta_pixel_encoder_core
// DPCM pixel encoder with a uniform quantizer and one shared serial divider.
//------------------------------------------------------------------------------
// Usage:
//   req channel: one RGB pixel beat plus row_start flag (valid/ready).
//   rsp channel: one beat per pixel with three codes and three
//   reconstructed channel values (valid/ready), held in an output register.
//   Config: APB-style port, quant_step at byte address 0 (a step of 0
//   behaves as 1). Write only while the block is idle.
// Sequencing:
//   Row-start pixel: goes straight to StFinish, which loads the output
//   register and returns to idle.
//   Other pixels: channels go one after another through a single radix-4
//   restoring divider (setup, 4 divide steps, update per channel), then
//   StFinish loads the result. req_ready is high only in idle, so a new
//   pixel is accepted only once the previous one has left StFinish.
// Reset: synchronous, active high; previous reconstruction cleared to 0,
//   quant_step set to 1, no result pending.
// Stall: a result waiting in the output register does not block the next
//   accept; only loading the following result waits for the receiver.
//------------------------------------------------------------------------------
`default_nettype none

module quantized_delta_pixel_encoder_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire qdpe_pkg::req_data_type               req_data,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      qdpe_pkg::rsp_data_type               rsp_data,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [qdpe_pkg::AddrW-1:0]           paddr,
   input  wire logic [qdpe_pkg::DataW-1:0]           pwdata,
   output      logic [qdpe_pkg::DataW-1:0]           prdata,
   output      logic                                 pready
);

   localparam int unsigned PW = qdpe_pkg::PixW;
   localparam int unsigned NC = qdpe_pkg::NumChan;

   qdpe_pkg::state_type state_ff, state_in;

   logic [qdpe_pkg::ChanW-1:0]  ch_ff, ch_in;
   logic [1:0]                  cnt_ff, cnt_in;
   logic [NC-1:0][PW-1:0]       pix_ff, pix_in;
   logic [NC-1:0][PW-1:0]       prev_ff, prev_in;
   logic [NC-1:0][PW-1:0]       code_ff, code_in;
   logic [NC-1:0][PW-1:0]       recon_ff, recon_in;
   logic                        neg_ff, neg_in;
   logic [PW-1:0]               mag_ff, mag_in;
   logic [PW-1:0]               div_ff, div_in;
   logic [PW-1:0]               rem_ff, rem_in;
   logic [PW-1:0]               step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   qdpe_pkg::rsp_data_type      rsp_data_ff, rsp_data_in;

   logic [PW-1:0] step_eff;
   logic [PW-1:0] sel_pix;
   logic [PW-1:0] sel_prev;
   logic [PW:0]   step_a;
   logic [PW:0]   step_b;
   logic [PW-1:0] delta;
   logic          req_fire;
   logic          csr_wr;
   logic          out_free;

   assign step_eff = (step_ff == '0) ? PW'(1) : step_ff;
   assign sel_pix  = pix_ff[ch_ff];
   assign sel_prev = prev_ff[ch_ff];
   assign step_a   = qdpe_pkg::div_step(rem_ff, div_ff[PW-1], step_eff);
   assign step_b   = qdpe_pkg::div_step(step_a[PW-1:0], div_ff[PW-2], step_eff);
   assign delta    = mag_ff - rem_ff;
   assign req_fire = req_valid && req_ready;
   assign csr_wr   = psel && penable && pwrite
                     && (paddr[qdpe_pkg::AddrW-1] == qdpe_pkg::RegQuantStep);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == qdpe_pkg::StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[qdpe_pkg::AddrW-1] == qdpe_pkg::RegQuantStep)
                      ? {{(qdpe_pkg::DataW-PW){1'b0}}, step_ff} : '0;

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      cnt_in       = cnt_ff;
      pix_in       = pix_ff;
      prev_in      = prev_ff;
      code_in      = code_ff;
      recon_in     = recon_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      step_in      = csr_wr ? pwdata[PW-1:0] : step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         qdpe_pkg::StIdle: begin
            if (req_fire) begin
               pix_in = {req_data.pixel_blue, req_data.pixel_green, req_data.pixel_red};
               ch_in  = qdpe_pkg::ChanRed;
               if (req_data.row_start) begin
                  code_in  = {req_data.pixel_blue, req_data.pixel_green, req_data.pixel_red};
                  recon_in = {req_data.pixel_blue, req_data.pixel_green, req_data.pixel_red};
                  state_in = qdpe_pkg::StFinish;
               end else begin
                  state_in = qdpe_pkg::StSetup;
               end
            end
         end
         qdpe_pkg::StSetup: begin
            neg_in   = sel_pix < sel_prev;
            mag_in   = (sel_pix < sel_prev) ? (sel_prev - sel_pix) : (sel_pix - sel_prev);
            div_in   = (sel_pix < sel_prev) ? (sel_prev - sel_pix) : (sel_pix - sel_prev);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = qdpe_pkg::StDiv;
         end
         qdpe_pkg::StDiv: begin
            // two quotient bits per cycle; quotient shifts in from the bottom
            div_in = {div_ff[PW-3:0], step_a[PW], step_b[PW]};
            rem_in = step_b[PW-1:0];
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = qdpe_pkg::StPost;
            end
         end
         qdpe_pkg::StPost: begin
            // q*step equals magnitude minus remainder
            if (neg_ff) begin
               recon_in[ch_ff] = sel_prev - delta;
               code_in[ch_ff]  = qdpe_pkg::CodeBias - div_ff;
            end else begin
               recon_in[ch_ff] = sel_prev + delta;
               code_in[ch_ff]  = qdpe_pkg::CodeBias + div_ff;
            end
            if (ch_ff == qdpe_pkg::ChanBlue) begin
               state_in = qdpe_pkg::StFinish;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = qdpe_pkg::StSetup;
            end
         end
         qdpe_pkg::StFinish: begin
            if (out_free) begin
               prev_in      = recon_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{code_red:    code_ff[qdpe_pkg::ChanRed],
                                code_green:  code_ff[qdpe_pkg::ChanGreen],
                                code_blue:   code_ff[qdpe_pkg::ChanBlue],
                                recon_red:   recon_ff[qdpe_pkg::ChanRed],
                                recon_green: recon_ff[qdpe_pkg::ChanGreen],
                                recon_blue:  recon_ff[qdpe_pkg::ChanBlue]};
               state_in     = qdpe_pkg::StIdle;
            end
         end
         default: begin
            state_in = qdpe_pkg::StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qdpe_pkg::StIdle;
         ch_ff        <= qdpe_pkg::ChanRed;
         cnt_ff       <= '0;
         prev_ff      <= '0;
         step_ff      <= qdpe_pkg::StepReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         cnt_ff       <= cnt_in;
         prev_ff      <= prev_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      code_ff     <= code_in;
      recon_ff    <= recon_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

@@ hdl/qdpe_checker.sv @@
//------------------------------------------------------------------------------
// qdpe_checker
// Port-level checks for the delta pixel encoder, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module qdpe_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire qdpe_pkg::req_data_type         req_data,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire qdpe_pkg::rsp_data_type         rsp_data,
   input wire logic                           psel,
   input wire logic                           penable,
   input wire logic                           pwrite,
   input wire logic [qdpe_pkg::AddrW-1:0]     paddr,
   input wire logic [qdpe_pkg::DataW-1:0]     pwdata,
   input wire logic [qdpe_pkg::DataW-1:0]     prdata,
   input wire logic                           pready
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // one pixel at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted beat");

   // nothing pending straight out of reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result pending or busy after reset");

   // row-start pixel passes through with red and blue codes equal to their reconstructions
   a_row_start_pass: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.row_start && !rsp_valid |=> ##1
         rsp_valid && rsp_data.code_red == rsp_data.recon_red
         && rsp_data.code_blue == rsp_data.recon_blue)
      else $error("row-start beat not passed through");

endmodule

bind quantized_delta_pixel_encoder_core qdpe_checker u_qdpe_checker (.*);

`default_nettype wire

@@ bench/quantized_delta_pixel_encoder_core_tb.sv @@
//------------------------------------------------------------------------------
// quantized_delta_pixel_encoder_core_tb
// Drives pixel beats with random bursts and gaps, stalls the result channel
// on its own pattern, and writes the quantiser step between idle phases.
// A scoreboard predicts codes and reconstructions from its own copy of the
// step and the previous reconstruction, and checks every result beat.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module quantized_delta_pixel_encoder_core_tb;

   localparam int unsigned PixW  = qdpe_pkg::PixW;
   localparam int unsigned AddrW = qdpe_pkg::AddrW;
   localparam int unsigned DataW = qdpe_pkg::DataW;

   localparam logic [AddrW-1:0] StepAddr = AddrW'(4 * qdpe_pkg::RegQuantStep);

   class dpcm_scoreboard;
      qdpe_pkg::rsp_data_type expected_q[$];
      logic [PixW-1:0] quant_step;
      logic [PixW-1:0] prev_red;
      logic [PixW-1:0] prev_green;
      logic [PixW-1:0] prev_blue;
      int unsigned     faults;

      function new();
         quant_step = qdpe_pkg::StepReset;
         prev_red   = '0;
         prev_green = '0;
         prev_blue  = '0;
         faults     = 0;
      endfunction

      function void set_step(logic [PixW-1:0] s);
         quant_step = s;
      endfunction

      function logic [PixW-1:0] eff_step();
         return (quant_step == '0) ? PixW'(1) : quant_step;
      endfunction

      function logic [PixW-1:0] quantise_chan(logic [PixW-1:0] pix,
                                               logic [PixW-1:0] prev,
                                               output logic [PixW-1:0] recon);
         logic            neg;
         logic [PixW-1:0] mag;
         logic [PixW-1:0] q;
         logic [PixW-1:0] delta;
         logic [PixW-1:0] s;
         s     = eff_step();
         neg   = pix < prev;
         mag   = neg ? prev - pix : pix - prev;
         q     = mag / s;
         delta = q * s;
         recon = neg ? prev - delta : prev + delta;
         return neg ? qdpe_pkg::CodeBias - q : qdpe_pkg::CodeBias + q;
      endfunction

      function void note_pixel(qdpe_pkg::req_data_type px);
         qdpe_pkg::rsp_data_type e;
         if (px.row_start) begin
            e.code_red    = px.pixel_red;
            e.code_green  = px.pixel_green;
            e.code_blue   = px.pixel_blue;
            e.recon_red   = px.pixel_red;
            e.recon_green = px.pixel_green;
            e.recon_blue  = px.pixel_blue;
         end else begin
            e.code_red   = quantise_chan(px.pixel_red,   prev_red,   e.recon_red);
            e.code_green = quantise_chan(px.pixel_green, prev_green, e.recon_green);
            e.code_blue  = quantise_chan(px.pixel_blue,  prev_blue,  e.recon_blue);
         end
         prev_red   = e.recon_red;
         prev_green = e.recon_green;
         prev_blue  = e.recon_blue;
         expected_q.push_back(e);
      endfunction

      function void cmp_field(string name, logic [PixW-1:0] exp_v,
                              logic [PixW-1:0] got_v);
         if (got_v !== exp_v) begin
            faults++;
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
         end
      endfunction

      function void check_result(qdpe_pkg::rsp_data_type got);
         qdpe_pkg::rsp_data_type e;
         if (expected_q.size() == 0) begin
            faults++;
            $error("result beat with no pixel outstanding");
            return;
         end
         e = expected_q.pop_front();
         cmp_field("code_red",    e.code_red,    got.code_red);
         cmp_field("code_green",  e.code_green,  got.code_green);
         cmp_field("code_blue",   e.code_blue,   got.code_blue);
         cmp_field("recon_red",   e.recon_red,   got.recon_red);
         cmp_field("recon_green", e.recon_green, got.recon_green);
         cmp_field("recon_blue",  e.recon_blue,  got.recon_blue);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   qdpe_pkg::req_data_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   qdpe_pkg::rsp_data_type rsp_data;
   logic                   psel      = 1'b0;
   logic                   penable   = 1'b0;
   logic                   pwrite    = 1'b0;
   logic [AddrW-1:0]       paddr     = '0;
   logic [DataW-1:0]       pwdata    = '0;
   logic [DataW-1:0]       prdata;
   logic                   pready;

   dpcm_scoreboard sb = new();

   int burst_left     = 0;
   int results_seen   = 0;
   bit long_hold_done = 1'b0;

   quantized_delta_pixel_encoder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result beats
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_data);
         results_seen++;
      end
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int mode;
      int mode_left;
      int hold_cnt;
      mode      = 0;
      mode_left = 0;
      hold_cnt  = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         if (!long_hold_done && results_seen >= 500) begin
            long_hold_done = 1'b1;
            hold_cnt       = 400;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: begin
                  if ($urandom_range(0, 7) == 0) begin
                     hold_cnt = $urandom_range(5, 30);
                     rsp_ready <= 1'b0;
                  end else begin
                     rsp_ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   task automatic send_pixel(qdpe_pkg::req_data_type px);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_pixel(px);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_fields(logic [PixW-1:0] r, logic [PixW-1:0] g,
                              logic [PixW-1:0] b, logic rs);
      qdpe_pkg::req_data_type px;
      px.pixel_red   = r;
      px.pixel_green = g;
      px.pixel_blue  = b;
      px.row_start   = rs;
      send_pixel(px);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_step(logic [PixW-1:0] s);
      wait_drained();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= StepAddr;
      pwdata  <= {24'($urandom), s};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_step(s);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[PixW-1:0] !== s) begin
         sb.faults++;
         $error("quant_step readback mismatch: expected %0d, got %0d",
                s, prdata[PixW-1:0]);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [PixW-1:0] pick_chan(logic [PixW-1:0] prev, int kind);
      int s;
      int v;
      s = int'(sb.eff_step());
      case (kind)
         0: return PixW'($urandom_range(0, 255));
         1: begin
            v = int'(prev) + $urandom_range(0, 6 * s) - 3 * s;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return PixW'(v);
         end
         default: begin
            case ($urandom_range(0, 3))
               0: return 8'h00;
               1: return 8'h01;
               2: return 8'hFE;
               default: return 8'hFF;
            endcase
         end
      endcase
   endfunction

   function automatic qdpe_pkg::req_data_type random_pixel(logic rs);
      qdpe_pkg::req_data_type px;
      int                     sel;
      int                     kind;
      sel  = $urandom_range(0, 99);
      kind = (sel < 50) ? 0 : (sel < 85) ? 1 : 2;
      px.pixel_red   = pick_chan(sb.prev_red,   kind);
      px.pixel_green = pick_chan(sb.prev_green, kind);
      px.pixel_blue  = pick_chan(sb.prev_blue,  kind);
      px.row_start   = rs;
      return px;
   endfunction

   initial begin
      logic [PixW-1:0] phase_steps[8];
      int              sent;
      int              row_len;
      phase_steps = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd3,
                      PixW'($urandom_range(4, 127)), 8'd128,
                      PixW'($urandom_range(129, 254))};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset step of one, no row start yet
      send_fields(8'd200, 8'd17,  8'd255, 1'b0);
      send_fields(8'd0,   8'd0,   8'd0,   1'b0);
      send_fields(8'd255, 8'd255, 8'd255, 1'b1);
      send_fields(8'd0,   8'd0,   8'd0,   1'b0);
      send_fields(8'd255, 8'd128, 8'd1,   1'b1);
      send_fields(8'd255, 8'd128, 8'd1,   1'b0);

      // zero step behaves as one
      write_step(8'd0);
      send_fields(8'd10,  8'd250, 8'd0,   1'b1);
      send_fields(8'd11,  8'd0,   8'd255, 1'b0);

      write_step(8'd255);
      send_fields(8'd0,   8'd0,   8'd0,   1'b1);
      send_fields(8'd254, 8'd255, 8'd1,   1'b0);
      send_fields(8'd0,   8'd0,   8'd0,   1'b0);

      write_step(8'd7);
      send_fields(8'd100, 8'd100, 8'd100, 1'b1);
      send_fields(8'd93,  8'd107, 8'd94,  1'b0);
      send_fields(8'd255, 8'd0,   8'd170, 1'b0);

      write_step(8'd128);
      send_fields(8'd0,   8'd128, 8'd255, 1'b1);
      send_fields(8'd255, 8'd0,   8'd0,   1'b0);

      // rows of random length; a few rows lack their start flag
      foreach (phase_steps[p]) begin
         write_step(phase_steps[p]);
         sent = 0;
         while (sent < 200) begin
            row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 20);
            for (int i = 0; i < row_len && sent < 200; i++) begin
               if (i == 0)
                  send_pixel(random_pixel($urandom_range(0, 9) != 0));
               else
                  send_pixel(random_pixel($urandom_range(0, 19) == 0));
               sent++;
            end
         end
      end

      wait_drained();
      repeat (30) @(posedge clock);
      if (sb.faults == 0 && sb.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
